// ===== hw/rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] OPC_CLOSE = 4'd8;

    // header byte fields and special length codes
    localparam logic [7:0] BIT_TOP    = 8'h80;
    localparam logic [7:0] OPC_MASK   = 8'h0F;
    localparam logic [7:0] LEN7_MASK  = 8'h7F;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // queue between parser and output stage
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one result record as the parser classifies it; unmasking happens later
    typedef struct packed {
        logic [1:0]  kind;
        logic        fin;
        logic [3:0]  opcode;
        logic [63:0] length;
        logic [7:0]  data;
        logic [7:0]  key;
        logic        frame_end;
    } rec_t;

endpackage

// ===== hw/rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// receive-side websocket frame parser for client-to-server byte streams
// ----------------------------------------------------------------------------
// path: a result passes the parser register, the queue and the output
//   register on its way to the output ports
// throughput: one byte per cycle unless full, set by the per-byte state update
// reset: asynchronous active-low, parser returns to the first header byte,
//   queue and output stage empty, stopped state cleared
// ----------------------------------------------------------------------------
module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    // byte input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic        final_fragment,
    output logic [3:0]  frame_opcode,
    output logic [63:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        frame_end,
    output logic        link_closed
);

    logic                       take;
    logic                       rec_valid;
    wsd_pkg::rec_t              rec;
    logic                       head_valid;
    wsd_pkg::rec_t              head;
    logic                       head_take;
    logic [wsd_pkg::QCNT_W-1:0] q_count;
    logic [wsd_pkg::QCNT_W:0]   q_used;
    logic                       out_valid;

    // every byte may make a result, so count the record still in the
    // parser register against the queue space
    assign q_used = {1'b0, q_count} + {{wsd_pkg::QCNT_W{1'b0}}, rec_valid};
    assign full   = (q_used >= (wsd_pkg::QCNT_W + 1)'(wsd_pkg::QDEPTH));
    // an input transaction completes on push with room left
    assign take   = push && !full;

    // front end: header walk, length, key collection, byte tagging
    wsd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // decouples the parser from output back-pressure
    wsd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (rec_valid),
        .wr_data    (rec),
        .rd         (head_take),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    // back end: unmasking and the output register
    wsd_unmask u_unmask
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .head_take      (head_take),
        .pop            (pop),
        .out_valid      (out_valid),
        .kind           (kind),
        .final_fragment (final_fragment),
        .frame_opcode   (frame_opcode),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .frame_end      (frame_end),
        .link_closed    (link_closed)
    );

    assign empty = !out_valid;

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> kind == wsd_pkg::KIND_HEADER || kind == wsd_pkg::KIND_DATA
                   || kind == wsd_pkg::KIND_ERROR)
        else $error("result transaction with an undefined kind");

    a_closed_ends: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && link_closed |-> frame_end && frame_opcode == wsd_pkg::OPC_CLOSE)
        else $error("link_closed outside the end of a close frame");

endmodule

// ===== hw/rtl/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// front end: walks the frame header and tags every payload byte with its key byte
// ----------------------------------------------------------------------------
module wsd_parser
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    rx_byte,
    output logic          rec_valid,
    output wsd_pkg::rec_t rec
);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic          fin_reg, fin_next;
    logic [3:0]    opcode_reg, opcode_next;
    logic [63:0]   length_reg, length_next;
    logic [3:0]    ext_left_reg, ext_left_next;
    logic [31:0]   mask_key_reg, mask_key_next;
    logic [1:0]    key_lane_reg, key_lane_next;
    logic [63:0]   payload_left_reg, payload_left_next;
    logic          stopped_reg, stopped_next;
    logic          rec_valid_reg, rec_valid_next;
    wsd_pkg::rec_t rec_reg, rec_next;

    logic [6:0]    len7;
    logic [7:0]    key_byte;

    assign len7 = 7'(rx_byte & wsd_pkg::LEN7_MASK);

    always_comb
    begin
        case (key_lane_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        fin_next          = fin_reg;
        opcode_next       = opcode_reg;
        length_next       = length_reg;
        ext_left_next     = ext_left_reg;
        mask_key_next     = mask_key_reg;
        key_lane_next     = key_lane_reg;
        payload_left_next = payload_left_reg;
        stopped_next      = stopped_reg;
        rec_valid_next    = 1'b0;
        rec_next          = rec_reg;

        if (take && !stopped_reg)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    if ((rx_byte & wsd_pkg::BIT_TOP) == 8'd0)
                    begin
                        // unmasked frame: error and stop
                        rec_valid_next     = 1'b1;
                        rec_next.kind      = wsd_pkg::KIND_ERROR;
                        rec_next.fin       = fin_reg;
                        rec_next.opcode    = opcode_reg;
                        rec_next.length    = 64'd0;
                        rec_next.data      = 8'd0;
                        rec_next.key       = 8'd0;
                        rec_next.frame_end = 1'b1;
                        phase_next         = PH_HDR0;
                        stopped_next       = 1'b1;
                    end
                    else
                    begin
                        if (len7 == wsd_pkg::LEN_EXT16)
                        begin
                            length_next   = 64'd0;
                            ext_left_next = wsd_pkg::EXT16_BYTES;
                            phase_next    = PH_EXT;
                        end
                        else if (len7 == wsd_pkg::LEN_EXT64)
                        begin
                            length_next   = 64'd0;
                            ext_left_next = wsd_pkg::EXT64_BYTES;
                            phase_next    = PH_EXT;
                        end
                        else
                        begin
                            length_next   = {57'd0, len7};
                            ext_left_next = 4'd0;
                            phase_next    = PH_KEY;
                        end
                        key_lane_next = 2'd0;
                        mask_key_next = 32'd0;
                    end
                end
                PH_EXT:
                begin
                    // big-endian length, one byte a cycle while bytes are taken
                    length_next   = {length_reg[55:0], rx_byte};
                    ext_left_next = ext_left_reg - 4'd1;
                    if (ext_left_next == 4'd0)
                    begin
                        phase_next = PH_KEY;
                    end
                end
                PH_KEY:
                begin
                    mask_key_next = {mask_key_reg[23:0], rx_byte};
                    key_lane_next = key_lane_reg + 2'd1;
                    if (key_lane_reg == 2'd3)
                    begin
                        payload_left_next  = length_reg;
                        rec_valid_next     = 1'b1;
                        rec_next.kind      = wsd_pkg::KIND_HEADER;
                        rec_next.fin       = fin_reg;
                        rec_next.opcode    = opcode_reg;
                        rec_next.length    = length_reg;
                        rec_next.data      = 8'd0;
                        rec_next.key       = 8'd0;
                        if (length_reg == 64'd0)
                        begin
                            // empty frame ends on its header
                            rec_next.frame_end = 1'b1;
                            phase_next         = PH_HDR0;
                            if (opcode_reg == wsd_pkg::OPC_CLOSE)
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                        else
                        begin
                            rec_next.frame_end = 1'b0;
                            phase_next         = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    key_lane_next      = key_lane_reg + 2'd1;
                    payload_left_next  = payload_left_reg - 64'd1;
                    rec_valid_next     = 1'b1;
                    rec_next.kind      = wsd_pkg::KIND_DATA;
                    rec_next.fin       = fin_reg;
                    rec_next.opcode    = opcode_reg;
                    rec_next.length    = length_reg;
                    rec_next.data      = rx_byte;
                    rec_next.key       = key_byte;
                    rec_next.frame_end = (payload_left_next == 64'd0);
                    if (payload_left_next == 64'd0)
                    begin
                        phase_next = PH_HDR0;
                        if (opcode_reg == wsd_pkg::OPC_CLOSE)
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // first header byte, also any unknown phase code
                    fin_next    = ((rx_byte & wsd_pkg::BIT_TOP) != 8'd0);
                    opcode_next = 4'(rx_byte & wsd_pkg::OPC_MASK);
                    phase_next  = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR0;
            fin_reg          <= 1'b0;
            opcode_reg       <= 4'd0;
            length_reg       <= 64'd0;
            ext_left_reg     <= 4'd0;
            mask_key_reg     <= 32'd0;
            key_lane_reg     <= 2'd0;
            payload_left_reg <= 64'd0;
            stopped_reg      <= 1'b0;
            rec_valid_reg    <= 1'b0;
            rec_reg          <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            fin_reg          <= fin_next;
            opcode_reg       <= opcode_next;
            length_reg       <= length_next;
            ext_left_reg     <= ext_left_next;
            mask_key_reg     <= mask_key_next;
            key_lane_reg     <= key_lane_next;
            payload_left_reg <= payload_left_next;
            stopped_reg      <= stopped_next;
            rec_valid_reg    <= rec_valid_next;
            rec_reg          <= rec_next;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        $past(stopped_reg) && stopped_reg |-> !rec_valid_reg)
        else $error("parser produced a record while stopped");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid_reg && rec_reg.kind == wsd_pkg::KIND_ERROR |-> stopped_reg)
        else $error("error record without stopping the parser");

endmodule

// ===== hw/rtl/wsd_queue.sv =====
// ----------------------------------------------------------------------------
// wsd_queue
// short record queue between the parser and the output stage
// ----------------------------------------------------------------------------
module wsd_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr,
    input  wsd_pkg::rec_t              wr_data,
    input  logic                       rd,
    output logic                       head_valid,
    output wsd_pkg::rec_t              head,
    output logic [wsd_pkg::QCNT_W-1:0] count
);

    wsd_pkg::rec_t                slot_reg [wsd_pkg::QDEPTH];
    logic [wsd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [wsd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [wsd_pkg::QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + wsd_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + wsd_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + wsd_pkg::QCNT_W'(1);
        end
        else if (!wr && rd)
        begin
            count_next = count_reg - wsd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == wsd_pkg::QCNT_W'(wsd_pkg::QDEPTH) |-> !wr || rd)
        else $error("write into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> count_reg != '0)
        else $error("read from an empty queue");

endmodule

// ===== hw/rtl/wsd_unmask.sv =====
// ----------------------------------------------------------------------------
// wsd_unmask
// back end: unmasks payload bytes and holds the result for the consumer
// ----------------------------------------------------------------------------
module wsd_unmask
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  wsd_pkg::rec_t head,
    output logic          head_take,
    input  logic          pop,
    output logic          out_valid,
    output logic [1:0]    kind,
    output logic          final_fragment,
    output logic [3:0]    frame_opcode,
    output logic [63:0]   payload_length,
    output logic [7:0]    payload_byte,
    output logic          frame_end,
    output logic          link_closed
);

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg;
    logic        fin_reg;
    logic [3:0]  opcode_reg;
    logic [63:0] length_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic        closed_reg;

    // refill whenever the held result is gone or leaves this cycle
    assign head_take = head_valid && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (head_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_take)
        begin
            kind_reg   <= head.kind;
            fin_reg    <= head.fin;
            opcode_reg <= head.opcode;
            length_reg <= head.length;
            byte_reg   <= head.data ^ head.key;
            end_reg    <= head.frame_end;
            closed_reg <= head.frame_end && (head.kind != wsd_pkg::KIND_ERROR)
                          && (head.opcode == wsd_pkg::OPC_CLOSE);
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign final_fragment = fin_reg;
    assign frame_opcode   = opcode_reg;
    assign payload_length = length_reg;
    assign payload_byte   = byte_reg;
    assign frame_end      = end_reg;
    assign link_closed    = closed_reg;

endmodule

// ===== tb/tb_websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// self-checking bench for the websocket receive-side frame deframer
// ----------------------------------------------------------------------------
// masked client frames go in byte by byte with random idle gaps, results
// come out under random pop stalls
// the scoreboard mirrors the parser and checks every popped result field by field
// the stream ends with a close frame, an unmasked frame or a frame with a huge
// 64-bit length; the first two are followed by bytes that must be ignored
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;

    localparam int unsigned RX_BUDGET    = 1100;      // bytes sent after which random frames stop and the ending starts
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned WATCHDOG_NS  = 5_000_000;

    // how the payload length is carried in the second header byte
    typedef enum logic [1:0] {LEN_SHORT, LEN_WIDE16, LEN_WIDE64} len_enc_t;

    // one popped result, as seen on the output ports
    typedef struct packed {
        logic [1:0]  kind;
        logic        final_fragment;
        logic [3:0]  frame_opcode;
        logic [63:0] payload_length;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic        link_closed;
    } frame_result_t;

    // parser position inside a frame
    typedef enum logic [2:0] {ST_HDR0, ST_HDR1, ST_EXT, ST_KEY, ST_DATA} parse_st_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirrors the parser and holds the results still owed
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        parse_st_t     phase;
        logic          fin;
        logic [3:0]    opc;
        logic [63:0]   len_acc;
        logic [3:0]    ext_left;
        logic [31:0]   key;
        logic [1:0]    lane;
        logic [63:0]   remaining;
        logic          halted;
        frame_result_t pending_results[$];
        int            errors;

        function new();
            phase     = ST_HDR0;
            fin       = 1'b0;
            opc       = '0;
            len_acc   = '0;
            ext_left  = '0;
            key       = '0;
            lane      = '0;
            remaining = '0;
            halted    = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void owe_result(logic [1:0] k, logic [63:0] len, logic [7:0] data,
                                 logic last);
            frame_result_t r;
            logic          closed;
            closed = last && (k != wsd_pkg::KIND_ERROR) && (opc == wsd_pkg::OPC_CLOSE);
            r.kind           = k;
            r.final_fragment = fin;
            r.frame_opcode   = opc;
            r.payload_length = len;
            r.payload_byte   = data;
            r.frame_end      = last;
            r.link_closed    = closed;
            pending_results.push_back(r);
            if (last)
            begin
                phase = ST_HDR0;
                if (closed || k == wsd_pkg::KIND_ERROR)
                    halted = 1'b1;
            end
        endfunction

        // advance the parser mirror by one accepted byte
        function void absorb_byte(logic [7:0] b);
            logic [6:0] len7;
            int         shift;
            if (halted)
                return;
            case (phase)
                ST_HDR1:
                begin
                    len7 = b[6:0];
                    if ((b & wsd_pkg::BIT_TOP) == 8'h00)
                    begin
                        owe_result(wsd_pkg::KIND_ERROR, 64'd0, 8'h00, 1'b1);
                        return;
                    end
                    len_acc = '0;
                    if (len7 == wsd_pkg::LEN_EXT16)
                    begin
                        ext_left = wsd_pkg::EXT16_BYTES;
                        phase    = ST_EXT;
                    end
                    else if (len7 == wsd_pkg::LEN_EXT64)
                    begin
                        ext_left = wsd_pkg::EXT64_BYTES;
                        phase    = ST_EXT;
                    end
                    else
                    begin
                        len_acc  = {57'd0, len7};
                        ext_left = '0;
                        phase    = ST_KEY;
                    end
                    lane = '0;
                    key  = '0;
                end
                ST_EXT:
                begin
                    len_acc  = {len_acc[55:0], b};
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0)
                        phase = ST_KEY;
                end
                ST_KEY:
                begin
                    key  = {key[23:0], b};
                    lane = lane + 2'd1;
                    if (lane == 2'd0)
                    begin
                        remaining = len_acc;
                        if (len_acc == 64'd0)
                            owe_result(wsd_pkg::KIND_HEADER, 64'd0, 8'h00, 1'b1);
                        else
                        begin
                            phase = ST_DATA;
                            owe_result(wsd_pkg::KIND_HEADER, len_acc, 8'h00, 1'b0);
                        end
                    end
                end
                ST_DATA:
                begin
                    shift     = (3 - int'(lane)) * 8;
                    lane      = lane + 2'd1;
                    remaining = remaining - 64'd1;
                    owe_result(wsd_pkg::KIND_DATA, len_acc, b ^ key[shift +: 8],
                               remaining == 64'd0);
                end
                default:
                begin
                    fin   = b[7];
                    opc   = b[3:0];
                    phase = ST_HDR1;
                end
            endcase
        endfunction

        function void match_result(frame_result_t got);
            frame_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: kind %0d byte %02h", got.kind,
                       got.payload_byte);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.final_fragment != want.final_fragment)
            begin
                $error("final_fragment: expected %0d, got %0d", want.final_fragment,
                       got.final_fragment);
                errors++;
            end
            if (got.frame_opcode != want.frame_opcode)
            begin
                $error("frame_opcode: expected %0d, got %0d", want.frame_opcode,
                       got.frame_opcode);
                errors++;
            end
            if (got.payload_length != want.payload_length)
            begin
                $error("payload_length: expected %0h, got %0h", want.payload_length,
                       got.payload_length);
                errors++;
            end
            if (got.payload_byte != want.payload_byte)
            begin
                $error("payload_byte: expected %02h, got %02h", want.payload_byte,
                       got.payload_byte);
                errors++;
            end
            if (got.frame_end != want.frame_end)
            begin
                $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
                errors++;
            end
            if (got.link_closed != want.link_closed)
            begin
                $error("link_closed: expected %0d, got %0d", want.link_closed,
                       got.link_closed);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  kind;
    logic        final_fragment;
    logic [3:0]  frame_opcode;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic        link_closed;

    frame_scoreboard sb = new();
    int unsigned     bytes_sent = 0;
    int              calm_left = 0;   // gap picks left in a stretch with no idling

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    websocket_frame_deframer u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .kind           (kind),
        .final_fragment (final_fragment),
        .frame_opcode   (frame_opcode),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .frame_end      (frame_end),
        .link_closed    (link_closed)
    );

    // idle length for either side: mostly none or short, a few long,
    // and now and then a calm stretch with no idling at all
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // byte side: push stays high across back-to-back transactions and only
    // drops for an idle gap
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (full);
        sb.absorb_byte(b);
        bytes_sent++;
    endtask

    // one masked frame; n_data payload bytes are sent, which may fall short
    // of len for a frame that is never meant to finish
    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
                              input len_enc_t enc, input logic [63:0] len,
                              input logic [31:0] key, input longint unsigned n_data);
        logic [6:0] len7;
        len7 = (enc == LEN_SHORT) ? len[6:0] :
               (enc == LEN_WIDE16) ? wsd_pkg::LEN_EXT16 : wsd_pkg::LEN_EXT64;
        send_byte({fin, rsv, opc});
        send_byte({1'b1, len7});
        if (enc == LEN_WIDE16)
            for (int i = 1; i >= 0; i--)
                send_byte(len[i*8 +: 8]);
        else if (enc == LEN_WIDE64)
            for (int i = 7; i >= 0; i--)
                send_byte(len[i*8 +: 8]);
        for (int i = 3; i >= 0; i--)
            send_byte(key[i*8 +: 8]);
        for (longint unsigned i = 0; i < n_data; i++)
            send_byte(8'($urandom));
    endtask

    // random data frame, never a close
    task automatic send_random_frame();
        logic [3:0]  opc;
        len_enc_t    enc;
        logic [63:0] len;
        int          r;
        opc = 4'($urandom);
        if (opc == wsd_pkg::OPC_CLOSE)
            opc = opc ^ 4'h1;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            enc = LEN_SHORT;
            len = 64'($urandom_range(0, 12));
        end
        else if (r < 65)
        begin
            enc = LEN_SHORT;
            len = 64'($urandom_range(100, 125));
        end
        else if (r < 85)
        begin
            // wide 16-bit form, mostly short lengths not minimally encoded on purpose
            enc = LEN_WIDE16;
            len = (r < 80) ? 64'($urandom_range(0, 30)) : 64'($urandom_range(126, 300));
        end
        else
        begin
            enc = LEN_WIDE64;
            len = 64'($urandom_range(0, 30));
        end
        send_frame(1'($urandom), 3'($urandom), opc, enc, len, $urandom, len);
    endtask

    // ------------------------------------------------------------------------
    // result side: check every popped transaction, stall pop at random
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.match_result('{kind, final_fragment, frame_opcode, payload_length,
                                  payload_byte, frame_end, link_closed});
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop   <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int          ending;
        logic [63:0] huge_len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty frame, single byte with all-ones key and rsv bits,
        // 64-bit length form carrying a tiny length
        send_frame(1'b1, 3'b000, 4'h0, LEN_SHORT, 64'd0, 32'h0000_0000, 64'd0);
        send_frame(1'b0, 3'b111, 4'hF, LEN_WIDE16, 64'd1, 32'hFFFF_FFFF, 64'd1);
        send_frame(1'b1, 3'b010, 4'h2, LEN_WIDE64, 64'd2, 32'hA5C3_5A3C, 64'd2);

        // random well-formed frames
        while (bytes_sent < RX_BUDGET)
            send_random_frame();

        // ending: close frame, unmasked frame, or a frame too long to finish
        ending = $urandom_range(0, 2);
        if (ending == 0)
        begin
            huge_len = 64'($urandom_range(0, 5));
            send_frame(1'b1, 3'($urandom), wsd_pkg::OPC_CLOSE, LEN_SHORT, huge_len,
                       $urandom, huge_len);
        end
        else if (ending == 1)
        begin
            send_byte(8'($urandom));
            send_byte({1'b0, 7'($urandom)});
        end
        else
        begin
            huge_len = {1'b1, 31'($urandom), 32'($urandom)};
            send_frame(1'($urandom), 3'($urandom), 4'h1, LEN_WIDE64, huge_len, $urandom,
                       64'd20);
        end
        // once stopped, further bytes must leave no trace
        if (ending != 2)
            for (int i = 0; i < 10; i++)
                send_byte(8'($urandom));

        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_queue.sv
hw/rtl/wsd_unmask.sv
hw/rtl/websocket_frame_deframer.sv
tb/tb_websocket_frame_deframer.sv
